// File: rtl/array_insert_delete_search_unit_defines.svh
// Assertion macros shared by the array insert/delete/search unit
`ifndef ARRAY_INSERT_DELETE_SEARCH_UNIT_DEFINES_SVH
`define ARRAY_INSERT_DELETE_SEARCH_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AIDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define AIDS_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define AIDS_ASSERT(label, prop, msg)
`define AIDS_ASSERT_NR(label, prop, msg)
`endif
`endif

// File: rtl/aids_pkg.sv
// Types and constants of the array insert/delete/search unit
package aids_pkg;

    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        found_position;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]    count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_SHIFT,
        S_DEL_SHIFT,
        S_SEARCH,
        S_RD_WAIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_STEP,
        OP_PUT,
        OP_DEL_END,
        OP_READ_POS,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic    load;
        op_t     op;
        logic    finish;
        status_t status;
        logic    take_read;
        logic    take_found;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             ins_ok;
        logic             pos_ok;
        logic             step_done;
        logic             hit;
    } stat_t;

endpackage

// File: rtl/aids_ram.sv
// Generic single-write, single-read RAM with registered read data
module aids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/aids_ctrl.sv
// Command sequencer of the array insert/delete/search unit
`include "array_insert_delete_search_unit_defines.svh"
module aids_ctrl
    import aids_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next      = state_reg;
        ctrl.load       = 1'b0;
        ctrl.op         = OP_NOP;
        ctrl.finish     = 1'b0;
        ctrl.status     = ST_OK;
        ctrl.take_read  = 1'b0;
        ctrl.take_found = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.command)
                    CMD_INSERT:
                    begin
                        if (stat.ins_ok)
                        begin
                            ctrl.op    = OP_INIT;
                            state_next = S_INS_SHIFT;
                        end
                        else
                        begin
                            ctrl.finish = 1'b1;
                            ctrl.status = ST_BAD;
                            state_next  = S_IDLE;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (stat.pos_ok)
                        begin
                            ctrl.op    = OP_INIT;
                            state_next = S_DEL_SHIFT;
                        end
                        else
                        begin
                            ctrl.finish = 1'b1;
                            ctrl.status = ST_BAD;
                            state_next  = S_IDLE;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        ctrl.op    = OP_INIT;
                        state_next = S_SEARCH;
                    end
                    CMD_READ:
                    begin
                        if (stat.pos_ok)
                        begin
                            ctrl.op    = OP_READ_POS;
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            ctrl.finish = 1'b1;
                            ctrl.status = ST_BAD;
                            state_next  = S_IDLE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.op     = OP_CLEAR;
                        ctrl.finish = 1'b1;
                        state_next  = S_IDLE;
                    end
                    default:
                    begin
                        ctrl.finish = 1'b1;
                        ctrl.status = ST_BAD;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                if (stat.step_done)
                begin
                    ctrl.op     = OP_PUT;
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctrl.op = OP_STEP;
                end
            end
            S_DEL_SHIFT:
            begin
                if (stat.step_done)
                begin
                    ctrl.op     = OP_DEL_END;
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctrl.op = OP_STEP;
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    ctrl.finish     = 1'b1;
                    ctrl.take_found = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (stat.step_done)
                begin
                    ctrl.finish = 1'b1;
                    ctrl.status = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctrl.op = OP_STEP;
                end
            end
            S_RD_WAIT:
            begin
                ctrl.finish    = 1'b1;
                ctrl.take_read = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `AIDS_ASSERT(a_accept_busy, accept |=> busy, "accepted word did not raise busy")
    `AIDS_ASSERT(a_finish_free, ctrl.finish |=> !busy, "busy held after finish")

endmodule

// File: rtl/aids_dp.sv
// Datapath of the array insert/delete/search unit: entry memory, length, scan index
`include "array_insert_delete_search_unit_defines.svh"
module aids_dp
    import aids_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  request,
    input  ctrl_t ctrl,
    output stat_t stat,
    output logic  done,
    output rsp_t  result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int OUT_CW = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    logic [CMD_W-1:0]        cmd_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        idx_next;
    logic                    pend_reg;
    logic                    pend_next;
    logic [ADDR_W-1:0]       paddr_reg;
    logic [ADDR_W-1:0]       paddr_next;
    logic                    done_reg;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  fill_ext;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  paddr_ext;
    logic [OUT_CW-1:0] fill_wide;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  pos_p1;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] step_addr;
    logic              is_ins;
    logic              is_del;
    logic              more;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    aids_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_ext   = CMP_W'(pos_reg);
    assign fill_ext  = CMP_W'(fill_reg);
    assign idx_ext   = CMP_W'(idx_reg);
    assign paddr_ext = CMP_W'(paddr_reg);
    assign pos_addr  = pos_ext[ADDR_W-1:0];
    assign pos_p1    = CNT_W'(pos_ext) + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign is_ins    = (cmd_reg == CMD_INSERT);
    assign is_del    = (cmd_reg == CMD_DELETE);
    assign more      = is_ins ? (idx_ext > pos_ext) : (idx_reg < fill_reg);
    assign step_addr = is_ins ? idx_dec[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    assign stat.command   = cmd_reg;
    assign stat.ins_ok    = (pos_ext <= fill_ext) && (fill_reg < CNT_W'(DEPTH));
    assign stat.pos_ok    = (pos_ext < fill_ext);
    assign stat.step_done = !more && !pend_reg;
    assign stat.hit       = pend_reg && (ram_rdata == val_reg);

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = step_addr;
        ram_we    = 1'b0;
        ram_waddr = is_ins ? (paddr_reg + ADDR_W'(1)) : (paddr_reg - ADDR_W'(1));
        ram_wdata = ram_rdata;
        idx_next  = idx_reg;
        pend_next = 1'b0;
        paddr_next = paddr_reg;
        fill_next = fill_reg;
        case (ctrl.op)
            OP_INIT:
            begin
                if (is_ins)
                begin
                    idx_next = fill_reg;
                end
                else if (is_del)
                begin
                    idx_next = pos_p1;
                end
                else
                begin
                    idx_next = '0;
                end
            end
            OP_STEP:
            begin
                ram_re    = more;
                ram_we    = pend_reg && (is_ins || is_del);
                pend_next = more;
                if (more)
                begin
                    paddr_next = step_addr;
                    idx_next   = is_ins ? idx_dec : (idx_reg + CNT_W'(1));
                end
            end
            OP_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_addr;
                ram_wdata = val_reg;
                fill_next = fill_reg + CNT_W'(1);
            end
            OP_DEL_END:
            begin
                fill_next = fill_reg - CNT_W'(1);
            end
            OP_READ_POS:
            begin
                ram_re    = 1'b1;
                ram_raddr = pos_addr;
            end
            OP_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign fill_wide = OUT_CW'(fill_next);

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_next.status         = ctrl.status;
        rsp_next.found_position = ctrl.take_found ? paddr_ext[POS_W-1:0] : '0;
        rsp_next.read_value     = ctrl.take_read ? ram_rdata : '0;
        rsp_next.count          = fill_wide[CNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
            done_reg <= ctrl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg <= paddr_next;
        if (ctrl.load)
        begin
            cmd_reg <= request.command;
            pos_reg <= request.position;
            val_reg <= request.value;
        end
        if (ctrl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    `AIDS_ASSERT(a_put_grows, ctrl.op == OP_PUT |=> fill_reg == $past(fill_reg) + CNT_W'(1), "insert did not grow length")
    `AIDS_ASSERT(a_wr_range, ram_we |-> CNT_W'(ram_waddr) <= fill_reg, "write beyond array end")
    `AIDS_ASSERT_NR(a_done_quiet, done_reg |-> !pend_reg, "read in flight after result")

endmodule

// File: rtl/array_insert_delete_search_unit.sv
// Top level: dense array with insert, delete, search, read and clear commands
// Clear, read and rejected words need no scan; insert and delete shift the entries
// past the position one step at a time, and search compares entries from index 0
// until the first match or the end of the array.
// One word in flight; start is taken again in the cycle that done is shown.
// Reset clears length and controller, not entry memory; done lasts one cycle, no stall.
module array_insert_delete_search_unit
    import aids_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    ctrl_t ctrl;
    stat_t stat;

    aids_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    aids_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the array insert/delete/search unit
module testbench;
    import aids_pkg::*;

    localparam int DEPTH      = 64;
    localparam int MAX_GAP    = 15;
    localparam int RAND_WORDS = 1375;
    localparam int SETTLE     = DEPTH + 16;
    localparam int STALL_MAX  = 4000;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

    class shadow_array;
        logic signed [VAL_W-1:0] entries [DEPTH];
        int unsigned fill;
        rsp_t expected_results [$];
        int errors;

        function new();
            fill = 0;
            errors = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        function void take_word(req_t w);
            rsp_t r;
            r = '0;
            r.status = ST_OK;
            case (w.command)
                CMD_INSERT:
                begin
                    if (w.position <= fill && fill < DEPTH)
                    begin
                        for (int i = fill; i > w.position; i--)
                            entries[i] = entries[i-1];
                        entries[w.position] = w.value;
                        fill++;
                    end
                    else
                        r.status = ST_BAD;
                end
                CMD_DELETE:
                begin
                    if (w.position < fill)
                    begin
                        for (int i = w.position; i + 1 < fill; i++)
                            entries[i] = entries[i+1];
                        fill--;
                    end
                    else
                        r.status = ST_BAD;
                end
                CMD_SEARCH:
                begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (entries[i] == w.value)
                        begin
                            r.status = ST_OK;
                            r.found_position = POS_W'(i);
                            break;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (w.position < fill)
                        r.read_value = entries[w.position];
                    else
                        r.status = ST_BAD;
                end
                CMD_CLEAR:
                    fill = 0;
                default:
                    r.status = ST_BAD;
            endcase
            r.count = CNT_OUT_W'(fill);
            expected_results.push_back(r);
        endfunction

        function void check_word(rsp_t got);
            rsp_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d pos %0d read %0d count %0d",
                             got.status, got.found_position, got.read_value, got.count);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.found_position !== want.found_position ||
                got.read_value !== want.read_value || got.count !== want.count)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d pos %0d read %0d count %0d, got status %0d pos %0d read %0d count %0d",
                             want.status, want.found_position, want.read_value, want.count,
                             got.status, got.found_position, got.read_value, got.count);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    shadow_array sb = new();
    int calm_left = 0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    array_insert_delete_search_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_word(result);
            if (start && !busy)
                sb.take_word(request);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic req_t word_of(logic [CMD_W-1:0] c, int p, logic signed [VAL_W-1:0] v);
        req_t w;
        w.command = c;
        w.position = POS_W'(p);
        w.value = v;
        return w;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return VAL_W'($signed($urandom_range(0, 7)) - 4);
        if (roll < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '1;
            default: return '0;
        endcase
    endfunction

    function automatic int any_position();
        return $urandom_range(0, DEPTH - 1);
    endfunction

    function automatic int live_position();
        if (sb.fill == 0)
            return any_position();
        return $urandom_range(0, sb.fill - 1);
    endfunction

    function automatic req_t pick_word(bit growing);
        int roll;
        int top;
        logic signed [VAL_W-1:0] v;
        roll = $urandom_range(0, 99);
        top = (sb.fill > DEPTH - 1) ? DEPTH - 1 : sb.fill;
        if (growing && roll < 75)
        begin
            if ($urandom_range(0, 1) == 0)
                return word_of(CMD_INSERT, top, pick_value());
            return word_of(CMD_INSERT, $urandom_range(0, top), pick_value());
        end
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return word_of(CMD_INSERT, $urandom_range(0, top), pick_value());
        if (roll < 45)
            return word_of(CMD_DELETE, live_position(), pick_value());
        if (roll < 70)
        begin
            if (sb.fill > 0 && $urandom_range(0, 99) < 55)
                v = sb.entries[$urandom_range(0, sb.fill - 1)];
            else
                v = pick_value();
            return word_of(CMD_SEARCH, any_position(), v);
        end
        if (roll < 88)
            return word_of(CMD_READ, live_position(), pick_value());
        if (roll < 92)
            return word_of(CMD_CLEAR, any_position(), pick_value());
        if (roll < 95)
            return word_of(CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, (1 << CMD_W) - 1)),
                           any_position(), pick_value());
        if (roll < 98)
            return word_of(CMD_INSERT, any_position(), pick_value());
        return word_of($urandom_range(0, 1) ? CMD_DELETE : CMD_READ, any_position(),
                       pick_value());
    endfunction

    task automatic drive_word(input req_t w);
        int gap;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else
        begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 39) == 0)
                calm_left = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= w;
        do @(posedge clk); while (busy);
    endtask

    task automatic run_directed();
        drive_word(word_of(CMD_READ, 0, '0));
        drive_word(word_of(CMD_DELETE, 0, '0));
        drive_word(word_of(CMD_SEARCH, 0, '0));
        drive_word(word_of(CMD_INSERT, 1, 32'sd5));
        drive_word(word_of(CMD_INSERT, 0, VAL_MAX));
        drive_word(word_of(CMD_INSERT, 0, VAL_MIN));
        drive_word(word_of(CMD_INSERT, 2, '1));
        drive_word(word_of(CMD_INSERT, 1, '0));
        drive_word(word_of(CMD_SEARCH, 0, '1));
        drive_word(word_of(CMD_SEARCH, DEPTH - 1, VAL_MIN));
        drive_word(word_of(CMD_SEARCH, 0, 32'sd12345));
        drive_word(word_of(CMD_READ, 0, '0));
        drive_word(word_of(CMD_READ, 3, '0));
        drive_word(word_of(CMD_READ, 4, '0));
        drive_word(word_of(CMD_READ, DEPTH - 1, '0));
        drive_word(word_of(CMD_INSERT, DEPTH - 1, VAL_MAX));
        drive_word(word_of(CMD_DELETE, 1, '0));
        drive_word(word_of(CMD_DELETE, 2, '0));
        drive_word(word_of(CMD_DELETE, 5, '0));
        for (int c = int'(CMD_CLEAR) + 1; c < (1 << CMD_W); c++)
            drive_word(word_of(CMD_W'(c), DEPTH - 1, '1));
        drive_word(word_of(CMD_CLEAR, DEPTH - 1, VAL_MIN));
        drive_word(word_of(CMD_SEARCH, 0, '1));
        drive_word(word_of(CMD_INSERT, 0, 32'sh5555_5555));
    endtask

    task automatic run_random(input int n);
        bit growing;
        int target;
        int churn_left;
        growing = 1'b1;
        target = DEPTH;
        churn_left = 0;
        for (int k = 0; k < n; k++)
        begin
            if (growing && sb.fill >= target)
            begin
                growing = 1'b0;
                churn_left = $urandom_range(5, 40);
            end
            else if (!growing && churn_left == 0)
            begin
                growing = 1'b1;
                target = ($urandom_range(0, 2) == 0) ? DEPTH : $urandom_range(1, DEPTH);
                if ($urandom_range(0, 3) == 0)
                begin
                    drive_word(word_of(CMD_CLEAR, any_position(), pick_value()));
                    continue;
                end
            end
            if (!growing)
                churn_left--;
            drive_word(pick_word(growing));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RAND_WORDS);
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
